/* rtl/wma_pkg.sv */
// Package for the windowed moving average block.
// Holds the ring sizes, the sequencer state and control types and the window length clamp.
// Used by windowed_moving_average and wma_checker; depends on nothing else.
package wma_pkg;

  localparam int unsigned WindowMax = 64;
  localparam int unsigned SlotW     = $clog2(WindowMax);
  localparam int unsigned LenW      = 7;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned SumW      = 22;
  localparam int unsigned BitCntW   = $clog2(SumW);

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDivide,
    StDone
  } wma_state_e;

  typedef struct packed {
    logic in_take;
    logic update;
    logic div_step;
    logic out_load;
  } wma_ctrl_t;

  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = len;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(WindowMax)) begin
      res = LenW'(WindowMax);
    end
    return res;
  endfunction

endpackage

/* rtl/windowed_moving_average.sv */
// Top level of the windowed moving average block.
// Holds the sample ring, the running sum and a bit-serial divider.
// Depends on wma_pkg.
//
// Usage: one signed 16-bit sample enters on the input channel (in_valid_i,
// in_stall_o, sample_i) and one result leaves on the output channel
// (out_valid_o, out_stall_i, average_o, window_sum_o, sample_count_o).
// An item is taken at a clock edge where valid is high and stall is low.
// The window length register is written through window_len_we_i and
// window_len_i; a write restarts the fill. Zero is taken as one and values
// above 64 as 64. Write it only while the block is idle.
// From acceptance to a valid result an item passes these steps: the oldest
// ring entry is read at the accepting edge, the update state refreshes the
// running sum and ring, the restoring divider in the divide state produces
// one quotient bit per cycle, and the done state loads the output register.
// A new item can be accepted in the cycle after the result is loaded, not
// before. The output register holds its item while out_stall_i is high; the
// block finishes the next item and then waits for the register to drain.
// Reset empties the window, sets the length to 64 and drops any pending
// result. The ring needs no clearing pass.
module windowed_moving_average (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              window_len_we_i,
  input  logic [wma_pkg::LenW-1:0]          window_len_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [wma_pkg::SampleW-1:0] sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wma_pkg::SampleW-1:0] average_o,
  output logic signed [wma_pkg::SumW-1:0]    window_sum_o,
  output logic [wma_pkg::LenW-1:0]          sample_count_o
);
  import wma_pkg::*;

  wma_state_e state_q, state_d;
  wma_ctrl_t  ctrl;

  logic [SampleW-1:0] ring_q [WindowMax];
  logic [SampleW-1:0] rdata_q;
  logic [SampleW-1:0] sample_q;

  logic [LenW-1:0]    window_len_q;
  logic [LenW-1:0]    fill_q, fill_d;
  logic [SlotW-1:0]   oldest_q, oldest_d;
  logic [SumW-1:0]    total_q, total_d;
  logic [BitCntW-1:0] bit_cnt_q;
  logic               out_valid_q;

  logic               neg_q;
  logic [LenW-1:0]    rem_q;
  logic [SumW-1:0]    dvd_q;
  logic [SumW-1:0]    quot;
  logic [LenW:0]      trial;
  logic               trial_ge;

  logic [LenW-1:0]    len;
  logic               full;
  logic [SlotW-1:0]   wr_slot;
  logic [SumW-1:0]    old_ext;
  logic [SumW-1:0]    abs_total;

  logic signed [SampleW-1:0] avg_q;
  logic signed [SumW-1:0]    sum_q;
  logic [LenW-1:0]           cnt_q;

  assign len  = eff_len(window_len_q);
  assign full = (fill_q >= len);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StUpdate;
        end
      end
      StUpdate: state_d = StDivide;
      StDivide: begin
        if (bit_cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      StIdle:   ctrl.in_take  = in_valid_i;
      StUpdate: ctrl.update   = 1'b1;
      StDivide: ctrl.div_step = 1'b1;
      StDone:   ctrl.out_load = !out_valid_q || !out_stall_i;
      default:  ctrl = '0;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    old_ext = full ? {{(SumW-SampleW){rdata_q[SampleW-1]}}, rdata_q} : '0;
    total_d = total_q + {{(SumW-SampleW){sample_q[SampleW-1]}}, sample_q} - old_ext;
    abs_total = total_d[SumW-1] ? (~total_d + SumW'(1)) : total_d;
    fill_d   = fill_q;
    oldest_d = oldest_q;
    wr_slot  = oldest_q;
    if (!full) begin
      fill_d  = fill_q + LenW'(1);
      wr_slot = fill_q[SlotW-1:0];
    end else if (({1'b0, oldest_q} + LenW'(1)) >= len) begin
      oldest_d = '0;
    end else begin
      oldest_d = oldest_q + SlotW'(1);
    end
  end

  assign trial    = {rem_q, dvd_q[SumW-1]};
  assign trial_ge = (trial >= {1'b0, fill_q});
  assign quot     = neg_q ? (~dvd_q + SumW'(1)) : dvd_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= ring_q[oldest_q];
    if (ctrl.update) begin
      ring_q[wr_slot] <= sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      window_len_q <= LenW'(WindowMax);
      fill_q       <= '0;
      oldest_q     <= '0;
      total_q      <= '0;
      bit_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (window_len_we_i) begin
        window_len_q <= window_len_i;
        fill_q       <= '0;
        oldest_q     <= '0;
        total_q      <= '0;
      end else if (ctrl.update) begin
        fill_q   <= fill_d;
        oldest_q <= oldest_d;
        total_q  <= total_d;
      end
      if (ctrl.update) begin
        bit_cnt_q <= BitCntW'(SumW - 1);
      end else if (ctrl.div_step && bit_cnt_q != '0) begin
        bit_cnt_q <= bit_cnt_q - BitCntW'(1);
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.in_take) begin
      sample_q <= sample_i;
    end
    if (ctrl.update) begin
      neg_q <= total_d[SumW-1];
      dvd_q <= abs_total;
      rem_q <= '0;
    end else if (ctrl.div_step) begin
      rem_q <= trial_ge ? LenW'(trial - {1'b0, fill_q}) : trial[LenW-1:0];
      dvd_q <= {dvd_q[SumW-2:0], trial_ge};
    end
    if (ctrl.out_load) begin
      avg_q <= quot[SampleW-1:0];
      sum_q <= total_q;
      cnt_q <= fill_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_o      = avg_q;
  assign window_sum_o   = sum_q;
  assign sample_count_o = cnt_q;

endmodule

/* rtl/wma_checker.sv */
// Port-level checker for the windowed moving average block.
// Watches the top level's ports only and is bound to it below.
// Depends on wma_pkg.
module wma_port_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [wma_pkg::SampleW-1:0] average_o,
  input logic signed [wma_pkg::SumW-1:0]    window_sum_o,
  input logic [wma_pkg::LenW-1:0]           sample_count_o
);
  import wma_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o)
      && $stable(window_sum_o) && $stable(sample_count_o))
    else $error("Stalled result item changed.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again while an item is in progress.");

  a_no_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##1 !$rose(out_valid_o))
    else $error("Result item appeared too soon after its sample.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0 && sample_count_o <= LenW'(WindowMax))
    else $error("Sample count out of range.");

endmodule

bind windowed_moving_average wma_port_checker u_wma_checker (.*);
